>>> rtl/dam_pkg.sv
// Shared types, command and register codes, and defaults for the
// adjacency-matrix shortest-path block. No dependencies.
`timescale 1ns / 1ps

package dam_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int WEIGHT_BITS_DEF  = 16;
   localparam int DIST_W           = 16;
   localparam int PRED_W           = 7;
   localparam int VERTEX_W         = 6;
   localparam int COUNT_W          = 7;

   typedef logic [DIST_W-1:0]   dist_type;
   typedef logic [PRED_W-1:0]   pred_type;
   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [1:0]          cmd_type;
   typedef logic [1:0]          csr_idx_type;

   // Predecessor code for "no previous vertex" (-1 in seven bits).
   localparam pred_type NO_PRED = 7'h7F;

   localparam cmd_type CMD_CLEAR = 2'd0;
   localparam cmd_type CMD_WRITE = 2'd1;
   localparam cmd_type CMD_RUN   = 2'd2;

   localparam csr_idx_type CSR_VERTEX_COUNT = 2'd0;
   localparam csr_idx_type CSR_START_VERTEX = 2'd1;
   localparam csr_idx_type CSR_NO_EDGE      = 2'd2;

   localparam count_type  VERTEX_COUNT_RST = 7'd64;
   localparam vertex_type START_VERTEX_RST = 6'd0;
   localparam dist_type   NO_EDGE_RST      = 16'd10000;

endpackage

>>> rtl/dijkstra_adjacency_matrix.sv
// Top level of the single-source shortest-path block over a weight matrix.
// Depends on dam_pkg; holds the weight memory and the per-vertex memory.
`timescale 1ns / 1ps
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  command, from_vertex, to_vertex, edge_weight
//  rsp      out        rsp_valid / rsp_ready  vertex, distance, predecessor, last
//  csr      in         csr_we                 csr_index, csr_wdata
//
// An edge write leaves the block in its idle state, so it is ready again at once.
// A clear sweeps the weight memory, one entry a cycle.
// A run first sets up the vertex table for the vertices in use, then
// makes one pass over the single vertex memory port for each settled
// vertex, then reads the results out one at a time as the output register frees.
// Reset is synchronous; a stalled result holds in the output register and
// the block still takes the next command once the last result is loaded.

module dijkstra_adjacency_matrix #(
   parameter int MAX_VERTICES = dam_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = dam_pkg::WEIGHT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dam_pkg::cmd_type         req_command,
   input  dam_pkg::vertex_type      req_from_vertex,
   input  dam_pkg::vertex_type      req_to_vertex,
   input  dam_pkg::dist_type        req_edge_weight,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dam_pkg::vertex_type      rsp_vertex,
   output dam_pkg::dist_type        rsp_distance,
   output logic signed [6:0]        rsp_predecessor,
   output logic                     rsp_last,
   input  logic                     csr_we,
   input  dam_pkg::csr_idx_type     csr_index,
   input  dam_pkg::dist_type        csr_wdata
);

   localparam int VB    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = (WEIGHT_BITS < dam_pkg::DIST_W) ? WEIGHT_BITS : dam_pkg::DIST_W;

   localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_VERTICES);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_INIT  = 3'd2;
   localparam logic [2:0] S_RELAX = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   // One entry per vertex: settled flag, predecessor and distance.
   typedef struct packed {
      logic              settled;
      dam_pkg::pred_type pred;
      dam_pkg::dist_type distance;
   } vrec_type;

   // Control registers.
   logic [2:0]              state_ff, state_in;
   dam_pkg::count_type      vcount_ff, vcount_in;
   dam_pkg::vertex_type     start_ff, start_in;
   dam_pkg::dist_type       noedge_ff, noedge_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [VB-1:0]           idx_ff, idx_in;
   logic                    issue_ff, issue_in;
   logic                    rd_v_ff, rd_v_in;
   logic [VB-1:0]           rd_idx_ff, rd_idx_in;
   logic                    rd_last_ff, rd_last_in;
   logic [VB-1:0]           last_ff, last_in;
   logic                    src_ok_ff, src_ok_in;
   logic                    cand_found_ff, cand_found_in;
   logic                    out_valid_ff, out_valid_in;

   // Payload registers.
   logic [VB-1:0]           best_ff, best_in;
   dam_pkg::dist_type       best_d_ff, best_d_in;
   logic [VB-1:0]           cand_ff, cand_in;
   dam_pkg::dist_type       cand_d_ff, cand_d_in;
   dam_pkg::vertex_type     out_vertex_ff, out_vertex_in;
   dam_pkg::dist_type       out_dist_ff, out_dist_in;
   dam_pkg::pred_type       out_pred_ff, out_pred_in;
   logic                    out_last_ff, out_last_in;

   // Memories and their registered read data.
   dam_pkg::dist_type       wmem [DEPTH];
   vrec_type                vmem [MAX_VERTICES];
   dam_pkg::dist_type       w_q_ff;
   vrec_type                v_q_ff;

   logic                    w_we;
   logic [AW-1:0]           w_wa;
   dam_pkg::dist_type       w_wd;
   logic [AW-1:0]           w_ra;
   logic                    v_we;
   logic [VB-1:0]           v_wa;
   vrec_type                v_wd;

   logic [CW-1:0]           n_use;
   logic [CW-1:0]           n_m1;
   logic                    edge_in_range;
   dam_pkg::dist_type       edge_w;
   logic [AW-1:0]           edge_addr;
   logic [dam_pkg::DIST_W:0] sum;
   dam_pkg::dist_type       sat;
   logic                    lower;
   dam_pkg::dist_type       new_d;
   logic                    is_best;
   logic                    take;
   logic                    fin_found;
   logic [VB-1:0]           fin_idx;
   dam_pkg::dist_type       fin_d;
   logic                    out_free;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_vertex      = out_vertex_ff;
   assign rsp_distance    = out_dist_ff;
   assign rsp_predecessor = $signed(out_pred_ff);
   assign rsp_last        = out_last_ff;

   // Vertex count in use: zero counts as one, large values clamp.
   always_comb begin
      if (vcount_ff == '0) begin
         n_use = CW'(1);
      end else if (vcount_ff > dam_pkg::COUNT_W'(MAX_VERTICES)) begin
         n_use = CW'(MAX_VERTICES);
      end else begin
         n_use = CW'(vcount_ff);
      end
   end
   assign n_m1 = n_use - CW'(1);

   assign edge_in_range = ({1'b0, req_from_vertex} < dam_pkg::COUNT_W'(MAX_VERTICES)) &&
                          ({1'b0, req_to_vertex} < dam_pkg::COUNT_W'(MAX_VERTICES));
   assign edge_w    = dam_pkg::DIST_W'(req_edge_weight[EW-1:0]);
   assign edge_addr = AW'(req_from_vertex[VB-1:0]) * ROW_STRIDE + AW'(req_to_vertex[VB-1:0]);
   assign w_ra      = AW'(best_ff) * ROW_STRIDE + AW'(idx_ff);

   // Relaxation of the column that arrives from memory this cycle, and the
   // running search for the next vertex to settle over the updated values.
   // The vertex being expanded counts as settled before its flag is stored.
   always_comb begin
      sum     = {1'b0, best_d_ff} + {1'b0, w_q_ff};
      sat     = (sum > {1'b0, noedge_ff}) ? noedge_ff : sum[dam_pkg::DIST_W-1:0];
      lower   = (sat < v_q_ff.distance);
      new_d   = lower ? sat : v_q_ff.distance;
      is_best = (rd_idx_ff == best_ff);
      take    = !v_q_ff.settled && !is_best && (new_d < noedge_ff) &&
                (!cand_found_ff || (new_d < cand_d_ff));
      fin_found = cand_found_ff || take;
      fin_idx   = take ? rd_idx_ff : cand_ff;
      fin_d     = take ? new_d : cand_d_ff;
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      vcount_in     = vcount_ff;
      start_in      = start_ff;
      noedge_in     = noedge_ff;
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      rd_v_in       = rd_v_ff;
      rd_idx_in     = rd_idx_ff;
      rd_last_in    = rd_last_ff;
      last_in       = last_ff;
      src_ok_in     = src_ok_ff;
      cand_found_in = cand_found_ff;
      out_valid_in  = out_valid_ff;
      best_in       = best_ff;
      best_d_in     = best_d_ff;
      cand_in       = cand_ff;
      cand_d_in     = cand_d_ff;
      out_vertex_in = out_vertex_ff;
      out_dist_in   = out_dist_ff;
      out_pred_in   = out_pred_ff;
      out_last_in   = out_last_ff;
      w_we = 1'b0;
      w_wa = edge_addr;
      w_wd = edge_w;
      v_we = 1'b0;
      v_wa = idx_ff;
      v_wd.settled  = 1'b0;
      v_wd.pred     = dam_pkg::NO_PRED;
      v_wd.distance = noedge_ff;

      if (csr_we) begin
         case (csr_index)
            dam_pkg::CSR_VERTEX_COUNT: vcount_in = csr_wdata[dam_pkg::COUNT_W-1:0];
            dam_pkg::CSR_START_VERTEX: start_in  = csr_wdata[dam_pkg::VERTEX_W-1:0];
            dam_pkg::CSR_NO_EDGE:      noedge_in = csr_wdata;
            default: ;
         endcase
      end

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  dam_pkg::CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  dam_pkg::CMD_WRITE: begin
                     w_we = edge_in_range;
                  end
                  dam_pkg::CMD_RUN: begin
                     last_in    = n_m1[VB-1:0];
                     src_ok_in  = ({1'b0, start_ff} < dam_pkg::COUNT_W'(n_use));
                     idx_in     = '0;
                     state_in   = S_INIT;
                  end
                  default: ;
               endcase
            end
         end
         S_CLEAR: begin
            w_we = 1'b1;
            w_wa = clr_ff;
            w_wd = noedge_ff;
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_INIT: begin
            v_we = 1'b1;
            v_wd.distance = (src_ok_ff && (dam_pkg::VERTEX_W'(idx_ff) == start_ff)) ?
                            '0 : noedge_ff;
            if (idx_ff == last_ff) begin
               best_in   = start_ff[VB-1:0];
               best_d_in = '0;
               idx_in    = '0;
               issue_in  = 1'b1;
               rd_v_in   = 1'b0;
               // With a zero no-edge value even the source is not below it.
               if (src_ok_ff && (noedge_ff != '0)) begin
                  cand_found_in = 1'b0;
                  state_in      = S_RELAX;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               idx_in = idx_ff + VB'(1);
            end
         end
         S_RELAX: begin
            rd_v_in = issue_ff;
            if (issue_ff) begin
               rd_idx_in  = idx_ff;
               rd_last_in = (idx_ff == last_ff);
               if (idx_ff == last_ff) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + VB'(1);
               end
            end
            if (rd_v_ff) begin
               // The write trails the read by one entry; where both meet on the last entry, that read is unused.
               // The expanded vertex is never lowered, so its entry only gains
               // the settled flag.
               v_wa = rd_idx_ff;
               v_wd = v_q_ff;
               if (is_best) begin
                  v_we         = 1'b1;
                  v_wd.settled = 1'b1;
               end else if (lower) begin
                  v_we          = 1'b1;
                  v_wd.distance = new_d;
                  v_wd.pred     = dam_pkg::PRED_W'(best_ff);
               end
               cand_found_in = fin_found;
               cand_in       = fin_idx;
               cand_d_in     = fin_d;
               if (rd_last_ff) begin
                  idx_in   = '0;
                  issue_in = 1'b1;
                  rd_v_in  = 1'b0;
                  if (fin_found) begin
                     best_in       = fin_idx;
                     best_d_in     = fin_d;
                     cand_found_in = 1'b0;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_EMIT: begin
            if (rd_v_ff) begin
               out_valid_in  = 1'b1;
               out_vertex_in = dam_pkg::VERTEX_W'(rd_idx_ff);
               out_dist_in   = v_q_ff.distance;
               out_pred_in   = v_q_ff.pred;
               out_last_in   = rd_last_ff;
               rd_v_in       = 1'b0;
               if (rd_last_ff) begin
                  state_in = S_IDLE;
               end
            end else if (issue_ff && out_free) begin
               // The output register is free by the time the read data lands.
               rd_v_in    = 1'b1;
               rd_idx_in  = idx_ff;
               rd_last_in = (idx_ff == last_ff);
               if (idx_ff == last_ff) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + VB'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         vcount_ff     <= dam_pkg::VERTEX_COUNT_RST;
         start_ff      <= dam_pkg::START_VERTEX_RST;
         noedge_ff     <= dam_pkg::NO_EDGE_RST;
         clr_ff        <= '0;
         idx_ff        <= '0;
         issue_ff      <= 1'b0;
         rd_v_ff       <= 1'b0;
         rd_idx_ff     <= '0;
         rd_last_ff    <= 1'b0;
         last_ff       <= '0;
         src_ok_ff     <= 1'b0;
         cand_found_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vcount_ff     <= vcount_in;
         start_ff      <= start_in;
         noedge_ff     <= noedge_in;
         clr_ff        <= clr_in;
         idx_ff        <= idx_in;
         issue_ff      <= issue_in;
         rd_v_ff       <= rd_v_in;
         rd_idx_ff     <= rd_idx_in;
         rd_last_ff    <= rd_last_in;
         last_ff       <= last_in;
         src_ok_ff     <= src_ok_in;
         cand_found_ff <= cand_found_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff       <= best_in;
      best_d_ff     <= best_d_in;
      cand_ff       <= cand_in;
      cand_d_ff     <= cand_d_in;
      out_vertex_ff <= out_vertex_in;
      out_dist_ff   <= out_dist_in;
      out_pred_ff   <= out_pred_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_wa] <= w_wd;
      end
      w_q_ff <= wmem[w_ra];
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         vmem[v_wa] <= v_wd;
      end
      v_q_ff <= vmem[idx_ff];
   end

endmodule

>>> rtl/dam_checker.sv
// Port-level checks for the shortest-path block, bound to its top level.
// Depends on dam_pkg and on the ports of dijkstra_adjacency_matrix.
`timescale 1ns / 1ps

module dam_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input dam_pkg::cmd_type     req_command,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dam_pkg::vertex_type  rsp_vertex,
   input dam_pkg::dist_type    rsp_distance,
   input logic signed [6:0]    rsp_predecessor,
   input logic                 rsp_last
);

   // A stalled result stays offered with the same payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex) &&
      $stable(rsp_distance) && $stable(rsp_predecessor) && $stable(rsp_last))
      else $error("result changed while stalled");

   // While a run still has results to deliver, no new command is taken.
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("command port ready in the middle of a run's results");

   // After an edge write the command port is ready again in the next cycle.
   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == dam_pkg::CMD_WRITE) |=> req_ready)
      else $error("edge write did not return to ready");

   // A clear or a run leaves the command port busy in the next cycle.
   a_long_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      ((req_command == dam_pkg::CMD_CLEAR) || (req_command == dam_pkg::CMD_RUN))
      |=> !req_ready)
      else $error("clear or run accepted without a busy period");

endmodule

bind dijkstra_adjacency_matrix dam_checker u_dam_checker (.*);

>>> dv/tb_dijkstra_adjacency_matrix.sv
// Self-checking testbench for dijkstra_adjacency_matrix: directed and random command
// streams against a behavioral shortest-path predictor. Depends on dam_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_dijkstra_adjacency_matrix;

   localparam int MAXV         = dam_pkg::MAX_VERTICES_DEF;
   localparam int CYCLE_LIMIT  = 10000000;
   // A clear sweeps the whole matrix, so that bounds the time a silent command can take.
   localparam int DRAIN_CYCLES = MAXV * MAXV + 200;
   localparam dam_pkg::cmd_type CMD_UNUSED = 2'd3;

   typedef struct packed {
      dam_pkg::vertex_type vertex;
      dam_pkg::dist_type   distance;
      dam_pkg::pred_type   predecessor;
      logic                last;
   } path_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   dam_pkg::cmd_type     req_command = dam_pkg::CMD_CLEAR;
   dam_pkg::vertex_type  req_from_vertex = '0;
   dam_pkg::vertex_type  req_to_vertex = '0;
   dam_pkg::dist_type    req_edge_weight = '0;
   logic                 rsp_valid;
   logic                 rsp_ready;
   dam_pkg::vertex_type  rsp_vertex;
   dam_pkg::dist_type    rsp_distance;
   logic signed [6:0]    rsp_predecessor;
   logic                 rsp_last;
   logic                 csr_we = 1'b0;
   dam_pkg::csr_idx_type csr_index = dam_pkg::CSR_VERTEX_COUNT;
   dam_pkg::dist_type    csr_wdata = '0;

   logic ready_want  = 1'b0;
   logic hold_active = 1'b0;
   assign rsp_ready = ready_want && !hold_active;

   bit steady_flow = 1'b0;
   int error_count = 0;
   int items_sent  = 0;

   // Predictor state: a shadow of the matrix and the registers.
   dam_pkg::dist_type   weight_mem [MAXV][MAXV];
   dam_pkg::count_type  cfg_count   = dam_pkg::VERTEX_COUNT_RST;
   dam_pkg::vertex_type cfg_start   = dam_pkg::START_VERTEX_RST;
   dam_pkg::dist_type   cfg_no_edge = dam_pkg::NO_EDGE_RST;
   path_result_type     expected_paths [$];

   dijkstra_adjacency_matrix dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .req_edge_weight (req_edge_weight),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vertex      (rsp_vertex),
      .rsp_distance    (rsp_distance),
      .rsp_predecessor (rsp_predecessor),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic predict_command(dam_pkg::cmd_type cmd, dam_pkg::vertex_type from,
                                  dam_pkg::vertex_type to, dam_pkg::dist_type weight);
      dam_pkg::dist_type         path_dist [MAXV];
      dam_pkg::pred_type         pred [MAXV];
      bit                        settled [MAXV];
      int                        n;
      int                        best;
      logic [dam_pkg::DIST_W:0]  path_sum;
      path_result_type           r;
      case (cmd)
         dam_pkg::CMD_CLEAR: begin
            for (int i = 0; i < MAXV; i++)
               for (int j = 0; j < MAXV; j++)
                  weight_mem[i][j] = cfg_no_edge;
         end
         dam_pkg::CMD_WRITE: begin
            weight_mem[from][to] = weight;
         end
         dam_pkg::CMD_RUN: begin
            n = (cfg_count == 0) ? 1 : (cfg_count > MAXV) ? MAXV : int'(cfg_count);
            for (int i = 0; i < MAXV; i++) begin
               path_dist[i] = cfg_no_edge;
               pred[i]      = dam_pkg::NO_PRED;
               settled[i]   = 1'b0;
            end
            if (int'(cfg_start) < n) begin
               path_dist[cfg_start] = '0;
               do begin
                  best = -1;
                  for (int i = 0; i < n; i++)
                     if (!settled[i] && path_dist[i] < cfg_no_edge &&
                         (best < 0 || path_dist[i] < path_dist[best]))
                        best = i;
                  if (best >= 0) begin
                     settled[best] = 1'b1;
                     for (int v = 0; v < n; v++) begin
                        path_sum = {1'b0, path_dist[best]} + {1'b0, weight_mem[best][v]};
                        if (path_sum > {1'b0, cfg_no_edge})
                           path_sum = {1'b0, cfg_no_edge};
                        if (path_sum < {1'b0, path_dist[v]}) begin
                           path_dist[v] = path_sum[dam_pkg::DIST_W-1:0];
                           pred[v] = dam_pkg::pred_type'(best);
                        end
                     end
                  end
               end while (best >= 0);
            end
            for (int i = 0; i < n; i++) begin
               r.vertex      = dam_pkg::vertex_type'(i);
               r.distance    = path_dist[i];
               r.predecessor = pred[i];
               r.last        = (i == n - 1);
               expected_paths.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   // Offers one command; payload fields of anything but an edge write are random noise.
   task automatic send_command(dam_pkg::cmd_type cmd, int from, int to, int weight);
      int gap;
      if (cmd != dam_pkg::CMD_WRITE) begin
         from   = $urandom_range(0, MAXV - 1);
         to     = $urandom_range(0, MAXV - 1);
         weight = $urandom_range(0, 65535);
      end
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_from_vertex <= dam_pkg::vertex_type'(from);
      req_to_vertex   <= dam_pkg::vertex_type'(to);
      req_edge_weight <= dam_pkg::dist_type'(weight);
      do @(posedge clock); while (!req_ready);
      predict_command(cmd, dam_pkg::vertex_type'(from), dam_pkg::vertex_type'(to),
                      dam_pkg::dist_type'(weight));
      if (cmd != CMD_UNUSED)
         items_sent++;
   endtask

   // Writes all three registers on consecutive cycles; unused upper data bits are random.
   task automatic configure(int count, int start, int no_edge);
      dam_pkg::dist_type data;
      data = dam_pkg::dist_type'($urandom);
      data[dam_pkg::COUNT_W-1:0] = count[dam_pkg::COUNT_W-1:0];
      csr_we    <= 1'b1;
      csr_index <= dam_pkg::CSR_VERTEX_COUNT;
      csr_wdata <= data;
      cfg_count = data[dam_pkg::COUNT_W-1:0];
      @(posedge clock);
      data = dam_pkg::dist_type'($urandom);
      data[dam_pkg::VERTEX_W-1:0] = start[dam_pkg::VERTEX_W-1:0];
      csr_index <= dam_pkg::CSR_START_VERTEX;
      csr_wdata <= data;
      cfg_start = data[dam_pkg::VERTEX_W-1:0];
      @(posedge clock);
      csr_index <= dam_pkg::CSR_NO_EDGE;
      csr_wdata <= dam_pkg::dist_type'(no_edge);
      cfg_no_edge = dam_pkg::dist_type'(no_edge);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_paths.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_weight();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind == 0)
         return 0;
      if (kind == 1)
         return $urandom_range(0, 65535);
      if (kind == 2)
         return $urandom_range(int'(cfg_no_edge), 65535);
      return $urandom_range(1, (cfg_no_edge > 3) ? int'(cfg_no_edge) / 3 : 1);
   endfunction

   task automatic test_default_settings();
      send_command(dam_pkg::CMD_CLEAR, 0, 0, 0);
      send_command(dam_pkg::CMD_WRITE, 0, 63, 0);
      send_command(dam_pkg::CMD_WRITE, 63, 0, 65535);
      send_command(dam_pkg::CMD_WRITE, 0, 1, 1);
      // The sum reaches the no-edge value exactly, so vertex 2 stays unreachable.
      send_command(dam_pkg::CMD_WRITE, 1, 2, 9999);
      send_command(dam_pkg::CMD_WRITE, 0, 3, 10000);
      send_command(CMD_UNUSED, 0, 0, 0);
      send_command(dam_pkg::CMD_RUN, 0, 0, 0);
      wait_quiet();
   endtask

   task automatic test_small_graph();
      configure(5, 1, 100);
      send_command(dam_pkg::CMD_CLEAR, 0, 0, 0);
      send_command(dam_pkg::CMD_WRITE, 1, 2, 30);
      send_command(dam_pkg::CMD_WRITE, 1, 3, 30);
      // Both paths to vertex 4 cost 40; the strict compare keeps the first one found.
      send_command(dam_pkg::CMD_WRITE, 2, 4, 10);
      send_command(dam_pkg::CMD_WRITE, 3, 4, 10);
      send_command(dam_pkg::CMD_WRITE, 1, 0, 100);
      send_command(dam_pkg::CMD_WRITE, 1, 1, 0);
      send_command(dam_pkg::CMD_WRITE, 4, 0, 0);
      send_command(dam_pkg::CMD_RUN, 0, 0, 0);
      wait_quiet();
   endtask

   task automatic test_register_extremes();
      configure(0, 0, 10000);
      send_command(dam_pkg::CMD_RUN, 0, 0, 0);
      wait_quiet();
      configure(127, 63, 65535);
      send_command(dam_pkg::CMD_CLEAR, 0, 0, 0);
      send_command(dam_pkg::CMD_WRITE, 63, 5, 65534);
      send_command(dam_pkg::CMD_RUN, 0, 0, 0);
      wait_quiet();
      configure(3, 50, 10000);
      send_command(dam_pkg::CMD_RUN, 0, 0, 0);
      wait_quiet();
      configure(64, 0, 0);
      send_command(dam_pkg::CMD_CLEAR, 0, 0, 0);
      send_command(dam_pkg::CMD_RUN, 0, 0, 0);
      wait_quiet();
   endtask

   // Results are held off long enough that runs queue up behind the output register.
   task automatic test_result_backpressure();
      configure(6, 0, 500);
      send_command(dam_pkg::CMD_CLEAR, 0, 0, 0);
      for (int i = 0; i < 5; i++)
         send_command(dam_pkg::CMD_WRITE, i, i + 1, $urandom_range(0, 200));
      fork
         begin
            hold_active <= 1'b1;
            repeat (600) @(posedge clock);
            hold_active <= 1'b0;
         end
         begin
            repeat (4) begin
               send_command(dam_pkg::CMD_WRITE, $urandom_range(0, 5), $urandom_range(0, 5),
                            pick_weight());
               send_command(dam_pkg::CMD_RUN, 0, 0, 0);
            end
         end
      join
      wait_quiet();
   endtask

   task automatic test_random_graphs();
      int  n;
      int  n_used;
      int  start;
      int  no_edge;
      int  kind;
      bit  first;
      first = 1'b1;
      while (items_sent < 240) begin
         kind = $urandom_range(0, 19);
         n = (kind == 0) ? 64 : (kind == 1) ? $urandom_range(65, 127) :
             (kind == 2) ? 0 : $urandom_range(1, 12);
         n_used = (n == 0) ? 1 : (n > MAXV) ? MAXV : n;
         start = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                             : $urandom_range(0, n_used - 1);
         kind = $urandom_range(0, 9);
         no_edge = (kind == 0) ? 65535 : (kind == 1) ? $urandom_range(1, 3) :
                   (kind == 2) ? $urandom_range(0, 65535) : $urandom_range(20, 2000);
         configure(n, start, no_edge);
         steady_flow = ($urandom_range(0, 3) == 0);
         // Skipping the clear now and then leaves entries at an older no-edge value.
         if (first || $urandom_range(0, 3) != 0)
            send_command(dam_pkg::CMD_CLEAR, 0, 0, 0);
         first = 1'b0;
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(3, 15)) begin
               kind = $urandom_range(0, 15);
               if (kind == 0)
                  send_command(CMD_UNUSED, 0, 0, 0);
               else if (kind == 1)
                  send_command(dam_pkg::CMD_WRITE, $urandom_range(0, 63),
                               $urandom_range(0, 63), $urandom_range(0, 65535));
               else
                  send_command(dam_pkg::CMD_WRITE, $urandom_range(0, n_used - 1),
                               $urandom_range(0, n_used - 1), pick_weight());
            end
            send_command(dam_pkg::CMD_RUN, 0, 0, 0);
         end
         wait_quiet();
      end
      steady_flow = 1'b0;
   endtask

   initial begin : result_acceptor
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            ready_want <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         ready_want <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin : check_results
      path_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_paths.size() == 0) begin
            $error("unexpected result transfer for vertex %0d", rsp_vertex);
            error_count++;
         end else begin
            exp_r = expected_paths.pop_front();
            if (rsp_vertex !== exp_r.vertex) begin
               $error("vertex: expected %0d, actual %0d", exp_r.vertex, rsp_vertex);
               error_count++;
            end
            if (rsp_distance !== exp_r.distance) begin
               $error("distance: expected %0d, actual %0d", exp_r.distance, rsp_distance);
               error_count++;
            end
            if (rsp_predecessor !== exp_r.predecessor) begin
               $error("predecessor: expected %0d, actual %0d",
                      $signed(exp_r.predecessor), rsp_predecessor);
               error_count++;
            end
            if (rsp_last !== exp_r.last) begin
               $error("last: expected %0d, actual %0d", exp_r.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_settings();
      test_small_graph();
      test_register_extremes();
      test_result_backpressure();
      test_random_graphs();
      wait_quiet();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
